// ----- src/sel_sort_pkg.sv -----
package sel_sort_pkg;

  // Default list capacity
  localparam int unsigned MaxItemsDef = 64;

  // Field widths
  localparam int unsigned CostW = 24;
  localparam int unsigned TagW  = 16;
  localparam int unsigned RecW  = CostW + TagW;

  // One stored record, cost in the low bits
  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [CostW-1:0] cost;
  } rec_t;

endpackage

// ----- src/sel_sort_ram.sv -----
module sel_sort_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/selection_sort_by_key.sv -----
// Loading: a list of n records is loaded at one word per cycle. After the word
//   marked tlast, each selection pass scans the unsorted tail for the lowest cost
//   and swaps it into place, using the single key comparator and the one RAM read port.
// Output: the next sorted word is read from storage only after the sink has taken the current one.
// Reset: rst_ni (async, active low) clears the sequencer, count and drop flag;
//   record storage is not cleared and needs no sweep.
module selection_sort_by_key
  #(
  parameter int unsigned MaxItems = sel_sort_pkg::MaxItemsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [sel_sort_pkg::RecW-1:0] s_axis_tdata,  // [23:0] cost, [39:24] tag
  input  logic                         s_axis_tlast,  // final_item
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [sel_sort_pkg::RecW-1:0] m_axis_tdata,  // [23:0] sorted_cost, [39:24] sorted_tag
  output logic                         m_axis_tlast,  // last_out
  output logic                         m_axis_tuser   // dropped
);

  import sel_sort_pkg::*;

  localparam int unsigned AW = (MaxItems > 1) ? $clog2(MaxItems) : 1;
  localparam int unsigned CW = $clog2(MaxItems + 1);

  typedef enum logic [7:0] {
    StLoad  = 8'b00000001,
    StRdPos = 8'b00000010,
    StScan  = 8'b00000100,
    StSwapA = 8'b00001000,
    StSwapB = 8'b00010000,
    StOutRd = 8'b00100000,
    StOutLd = 8'b01000000,
    StOutTx = 8'b10000000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] scan_q, scan_d;
  logic [CW-1:0] rd_q, rd_d;
  logic [CW-1:0] best_q, best_d;
  logic [CW-1:0] k_q, k_d;
  logic          out_valid_q, out_valid_d;
  logic          out_last_q, out_last_d;
  rec_t          best_rec_q, best_rec_d;
  rec_t          pos_rec_q, pos_rec_d;
  rec_t          out_rec_q, out_rec_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  rec_t          ram_wdata;
  logic [AW-1:0] ram_raddr;
  rec_t          ram_rdata;
  rec_t          in_rec;
  logic [CW-1:0] cnt_last;
  logic [CW-1:0] cnt_inc;

  assign in_rec   = rec_t'(s_axis_tdata);
  assign cnt_last = cnt_q - CW'(1);
  assign cnt_inc  = cnt_q + CW'(1);

  sel_sort_ram #(
    .Width(RecW),
    .Depth(MaxItems)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Sequencer: load, scan for minimum, swap, read out
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    pos_d       = pos_q;
    scan_d      = scan_q;
    rd_d        = rd_q;
    best_d      = best_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    best_rec_d  = best_rec_q;
    pos_rec_d   = pos_rec_q;
    out_rec_d   = out_rec_q;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q[AW-1:0];
    ram_wdata   = in_rec;
    ram_raddr   = scan_q[AW-1:0];

    unique case (state_q)
      StLoad: begin
        if (s_axis_tvalid) begin
          if (cnt_q < CW'(MaxItems)) begin
            ram_we = 1'b1;
            cnt_d  = cnt_inc;
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            pos_d = '0;
            k_d   = '0;
            if (cnt_d < CW'(2)) begin
              state_d = StOutRd;
            end else begin
              state_d = StRdPos;
            end
          end
        end
      end
      StRdPos: begin
        ram_raddr = pos_q[AW-1:0];
        rd_d      = pos_q;
        scan_d    = pos_q + CW'(1);
        state_d   = StScan;
      end
      StScan: begin
        // issue next probe while comparing the word that just came back
        ram_raddr = scan_q[AW-1:0];
        rd_d      = scan_q;
        scan_d    = scan_q + CW'(1);
        if (rd_q == pos_q) begin
          pos_rec_d  = ram_rdata;
          best_rec_d = ram_rdata;
          best_d     = pos_q;
        end else if (ram_rdata.cost < best_rec_q.cost) begin
          best_rec_d = ram_rdata;
          best_d     = rd_q;
        end
        if (rd_q == cnt_last) begin
          state_d = StSwapA;
        end
      end
      StSwapA: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[AW-1:0];
        ram_wdata = best_rec_q;
        state_d   = StSwapB;
      end
      StSwapB: begin
        ram_we    = 1'b1;
        ram_waddr = best_q[AW-1:0];
        ram_wdata = pos_rec_q;
        pos_d     = pos_q + CW'(1);
        if ((pos_q + CW'(2)) < cnt_q) begin
          state_d = StRdPos;
        end else begin
          state_d = StOutRd;
        end
      end
      StOutRd: begin
        ram_raddr = k_q[AW-1:0];
        state_d   = StOutLd;
      end
      StOutLd: begin
        out_rec_d   = ram_rdata;
        out_valid_d = 1'b1;
        out_last_d  = (k_q == cnt_last);
        state_d     = StOutTx;
      end
      StOutTx: begin
        if (m_axis_tready) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = StLoad;
          end else begin
            k_d     = k_q + CW'(1);
            state_d = StOutRd;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      pos_q       <= '0;
      scan_q      <= '0;
      rd_q        <= '0;
      best_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      pos_q       <= pos_d;
      scan_q      <= scan_d;
      rd_q        <= rd_d;
      best_q      <= best_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    best_rec_q <= best_rec_d;
    pos_rec_q  <= pos_rec_d;
    out_rec_q  <= out_rec_d;
  end

  assign s_axis_tready = (state_q == StLoad);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_rec_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = ovf_q;

endmodule

// ----- src/sel_sort_checker.sv -----
module sel_sort_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tlast,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [sel_sort_pkg::RecW-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);

  // Loading and readout never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a sorted word is pending");

  // A stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output word changed under stall");

  // The final input word closes the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still open after final word");

  // The last sorted word reopens the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("input not reopened after last sorted word");

  // Mid-run output keeps the input closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> !s_axis_tready)
    else $error("input reopened before run finished");

endmodule

bind selection_sort_by_key sel_sort_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
